// ===== design/stunad_pkg.sv =====
`default_nettype none

package stunad_pkg;

	// Fixed STUN values
	localparam logic [31:0] MAGIC_COOKIE = 32'h2112_A442;
	localparam logic [7:0]  FAMILY_IPV6  = 8'h02;
	localparam logic [16:0] HDR_SIZE     = 17'd4;
	localparam logic [4:0]  ADDR_V4_SIZE = 5'd4;
	localparam logic [4:0]  ADDR_V6_SIZE = 5'd16;
	localparam logic [7:0]  CLASS_MASK   = 8'h07;
	localparam logic [1:0]  LEN_ALIGN    = 2'h3;

	// Attribute type codes
	localparam logic [15:0] T_MAPPED_ADDRESS     = 16'h0001;
	localparam logic [15:0] T_ERROR_CODE         = 16'h0009;
	localparam logic [15:0] T_XOR_PEER_ADDRESS   = 16'h0012;
	localparam logic [15:0] T_XOR_RELAYED_ADDR   = 16'h0016;
	localparam logic [15:0] T_XOR_MAPPED_ADDRESS = 16'h0020;
	localparam logic [15:0] T_ALT_ADDRESS        = 16'h8023;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TID_HEAD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TID_TAIL = 1'b1;
	localparam int unsigned CFG_DATA_W = 64;

	typedef enum logic [2:0] {
		ROLE_HEADER   = 3'd0,
		ROLE_RESERVED = 3'd1,
		ROLE_FAMILY   = 3'd2,
		ROLE_PORT     = 3'd3,
		ROLE_ADDRESS  = 3'd4,
		ROLE_ERRCODE  = 3'd5,
		ROLE_VALUE    = 3'd6,
		ROLE_PADDING  = 3'd7
	} role_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_SHORT_BUF  = 2'd1,
		ST_LEN_TOO_BIG = 2'd2
	} status_t;

	// Per-attribute parse state
	typedef struct packed {
		logic [16:0] pos;
		logic [15:0] attr_type;
		logic [15:0] attr_len;
		logic [7:0]  family;
		logic [15:0] avail;
	} parse_state_t;

	// One decoded result item
	typedef struct packed {
		logic [7:0]  out_byte;
		role_t       byte_role;
		logic [15:0] attr_type;
		logic [15:0] attr_length;
		logic [16:0] consumed_total;
		logic        xor_type;
		logic        ipv6_family;
		logic        last;
		status_t     status;
	} result_t;

	function automatic logic is_xor_type(input logic [15:0] t);
		return (t == T_XOR_MAPPED_ADDRESS) || (t == T_XOR_PEER_ADDRESS) ||
			(t == T_XOR_RELAYED_ADDR);
	endfunction

	function automatic logic is_addr_type(input logic [15:0] t);
		return (t == T_MAPPED_ADDRESS) || (t == T_ALT_ADDRESS) || is_xor_type(t);
	endfunction

endpackage

`default_nettype wire

// ===== design/stunad_decode.sv =====
`default_nettype none

module stunad_decode (
	input  wire stunad_pkg::parse_state_t cur,
	input  wire logic [7:0]               data_byte,
	input  wire logic [15:0]              bytes_available,
	input  wire logic [31:0]              tid_head,
	input  wire logic [63:0]              tid_tail,
	output stunad_pkg::parse_state_t      nxt,
	output stunad_pkg::result_t           res
);

	logic [16:0]  body;
	logic [16:0]  addr_off;
	logic [4:0]   addr_size;
	logic [127:0] mask_vec;
	logic [15:0]  len_lo;
	logic [1:0]   len_rem;
	logic [2:0]   pad;
	logic [16:0]  consumed;
	logic         xor_now;
	logic [7:0]   ob;
	stunad_pkg::role_t   role;
	stunad_pkg::status_t status;
	logic         last;

	assign body      = cur.pos - stunad_pkg::HDR_SIZE;
	assign addr_off  = cur.pos - 17'd8;
	assign addr_size = (cur.family == stunad_pkg::FAMILY_IPV6) ?
		stunad_pkg::ADDR_V6_SIZE : stunad_pkg::ADDR_V4_SIZE;
	// Address mask bytes in order: cookie, transaction ID head, transaction ID tail
	assign mask_vec  = {stunad_pkg::MAGIC_COOKIE, tid_head, tid_tail};
	assign len_lo    = {cur.attr_len[15:8], data_byte};
	assign xor_now   = stunad_pkg::is_xor_type(cur.attr_type);

	// Step the parser by one byte
	always_comb begin
		nxt    = cur;
		ob     = data_byte;
		role   = stunad_pkg::ROLE_HEADER;
		status = stunad_pkg::ST_OK;
		last   = 1'b0;
		case (cur.pos)
			17'd0: begin
				nxt.avail     = bytes_available;
				nxt.attr_type = {data_byte, 8'h00};
				nxt.attr_len  = 16'h0000;
				nxt.family    = 8'h00;
				if (bytes_available < stunad_pkg::HDR_SIZE[15:0]) begin
					status = stunad_pkg::ST_SHORT_BUF;
					last   = 1'b1;
				end
			end
			17'd1: begin
				nxt.attr_type = {cur.attr_type[15:8], data_byte};
			end
			17'd2: begin
				nxt.attr_len = {data_byte, 8'h00};
			end
			17'd3: begin
				nxt.attr_len = len_lo;
				if (len_lo > cur.avail) begin
					status = stunad_pkg::ST_LEN_TOO_BIG;
					last   = 1'b1;
				end
			end
			default: begin
				if (body >= {1'b0, cur.attr_len}) begin
					role = stunad_pkg::ROLE_PADDING;
				end else if (stunad_pkg::is_addr_type(cur.attr_type)) begin
					if (cur.pos == 17'd4) begin
						role = stunad_pkg::ROLE_RESERVED;
					end else if (cur.pos == 17'd5) begin
						nxt.family = data_byte;
						role       = stunad_pkg::ROLE_FAMILY;
					end else if (cur.pos == 17'd6) begin
						role = stunad_pkg::ROLE_PORT;
						if (xor_now) ob = data_byte ^ stunad_pkg::MAGIC_COOKIE[31:24];
					end else if (cur.pos == 17'd7) begin
						role = stunad_pkg::ROLE_PORT;
						if (xor_now) ob = data_byte ^ stunad_pkg::MAGIC_COOKIE[23:16];
					end else if (addr_off < {12'h000, addr_size}) begin
						role = stunad_pkg::ROLE_ADDRESS;
						if (xor_now) ob = data_byte ^ mask_vec[{~addr_off[3:0], 3'b111} -: 8];
					end else begin
						role = stunad_pkg::ROLE_VALUE;
					end
				end else if (cur.attr_type == stunad_pkg::T_ERROR_CODE) begin
					if (cur.pos == 17'd4 || cur.pos == 17'd5) begin
						role = stunad_pkg::ROLE_RESERVED;
					end else if (cur.pos == 17'd6) begin
						role = stunad_pkg::ROLE_ERRCODE;
						ob   = data_byte & stunad_pkg::CLASS_MASK;
					end else if (cur.pos == 17'd7) begin
						role = stunad_pkg::ROLE_ERRCODE;
					end else begin
						role = stunad_pkg::ROLE_VALUE;
					end
				end else begin
					role = stunad_pkg::ROLE_VALUE;
				end
			end
		endcase

		// Total size once the length is known, and end of attribute
		len_rem  = nxt.attr_len[1:0] & stunad_pkg::LEN_ALIGN;
		pad      = (len_rem != 2'd0) ? (3'd4 - {1'b0, len_rem}) : 3'd0;
		consumed = 17'd0;
		if (cur.pos >= 17'd3 && status == stunad_pkg::ST_OK) begin
			consumed = stunad_pkg::HDR_SIZE + {1'b0, nxt.attr_len} + {14'h0000, pad};
			if (({1'b0, cur.pos} + 18'd1) >= {1'b0, consumed}) last = 1'b1;
		end

		nxt.pos = last ? 17'd0 : (cur.pos + 17'd1);
	end

	assign res.out_byte       = ob;
	assign res.byte_role      = role;
	assign res.attr_type      = nxt.attr_type;
	assign res.attr_length    = nxt.attr_len;
	assign res.consumed_total = consumed;
	assign res.xor_type       = stunad_pkg::is_xor_type(nxt.attr_type);
	assign res.ipv6_family    = (nxt.family == stunad_pkg::FAMILY_IPV6);
	assign res.last           = last;
	assign res.status         = status;

endmodule

`default_nettype wire

// ===== design/stun_attribute_decoder.sv =====
// Channel  | Dir | Ports                          | Content
// s_axis   | in  | s_tvalid s_tready s_tdata[23:0]| one attribute byte + buffer size
// m_axis   | out | m_tvalid m_tready m_tdata[63:0]| decoded byte, header fields, total
//          |     | m_tuser[6:0] m_tlast           | role/flags/status, end of attribute
// cfg      | in  | cfg_we cfg_index cfg_data[63:0]| transaction ID words
//
// One byte per cycle while the output is not stalled: an item sits in the input
// register, then the parser updates its state and writes the result register.
// The byte position and header registers are the only loop.
// arst_n clears both stage valids, the parse state and the transaction ID.
// A stalled output holds its result; the input stage keeps taking items while
// the input register is empty or moving on.
`default_nettype none

module stun_attribute_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tdata: [7:0] data_byte, [23:8] bytes_available
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,
	// m_tdata: [7:0] out_byte, [23:8] attr_type, [39:24] attr_length,
	//          [56:40] consumed_total, [63:57] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,
	// m_tuser: [2:0] byte_role, [3] xor_type, [4] ipv6_family, [6:5] status
	output logic [6:0]       m_tuser,
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [stunad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [stunad_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic [15:0] avail_s1;
	logic        v_s2;
	stunad_pkg::result_t      res_s2;
	stunad_pkg::parse_state_t st_q;
	stunad_pkg::parse_state_t st_nxt;
	stunad_pkg::result_t      res_nxt;
	logic [31:0] tid_head_q;
	logic [63:0] tid_tail_q;
	logic        adv_s1;

	assign adv_s1   = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tid_head_q <= '0;
			tid_tail_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == stunad_pkg::REG_TID_HEAD) tid_head_q <= cfg_data[31:0];
			if (cfg_index == stunad_pkg::REG_TID_TAIL) tid_tail_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata[7:0];
			avail_s1 <= s_tdata[23:8];
		end
	end

	stunad_decode u_decode (
		.cur             (st_q),
		.data_byte       (byte_s1),
		.bytes_available (avail_s1),
		.tid_head        (tid_head_q),
		.tid_tail        (tid_tail_q),
		.nxt             (st_nxt),
		.res             (res_nxt)
	);

	// Advance parse state as each item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) st_q <= st_nxt;
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) res_s2 <= res_nxt;
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {7'h00, res_s2.consumed_total, res_s2.attr_length,
		res_s2.attr_type, res_s2.out_byte};
	assign m_tuser  = {res_s2.status, res_s2.ipv6_family, res_s2.xor_type, res_s2.byte_role};
	assign m_tlast  = res_s2.last;

endmodule

`default_nettype wire

// ===== design/stunad_checker.sv =====
`default_nettype none

module stunad_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [6:0]  m_tuser,
	input wire logic        m_tlast
);

	// No result is offered during reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// Hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// Any error ends the attribute
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[6:5] != stunad_pkg::ST_OK |-> m_tlast)
		else $error("error without end of attribute");

	// Errors report no consumed size
	a_err_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[6:5] != stunad_pkg::ST_OK |-> m_tdata[56:40] == 17'd0)
		else $error("consumed size on error");

	// Padding only follows a known header, so the total is set
	a_pad_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] == stunad_pkg::ROLE_PADDING |-> m_tdata[56:40] >= 17'd4)
		else $error("padding without attribute size");

endmodule

bind stun_attribute_decoder stunad_checker u_stunad_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/sv/stun_attribute_decoder_test.sv =====
`default_nettype none

module stun_attribute_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT     = 300000;
	localparam int unsigned ITEMS_PER_PHASE = 270;
	localparam int unsigned NUM_PHASES      = 5;
	localparam int unsigned HOLDOFF_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES    = 16;
	localparam int unsigned NUM_DIRECTED    = 25;
	localparam int unsigned MAX_REPORTS     = 100;

	// One directed item, with the expected decode typed in where it is obvious
	typedef struct packed {
		logic [7:0]          data;
		logic [15:0]         avail;
		logic                typed;
		logic [7:0]          out_byte;
		stunad_pkg::role_t   role;
		logic                last;
		stunad_pkg::status_t status;
	} directed_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// s_tdata: [7:0] data_byte, [23:8] bytes_available
	logic [23:0]           s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	// m_tdata: [7:0] out_byte, [23:8] attr_type, [39:24] attr_length,
	//          [56:40] consumed_total, [63:57] zero
	logic [63:0]           m_tdata;
	// m_tuser: [2:0] byte_role, [3] xor_type, [4] ipv6_family, [6:5] status
	logic [6:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [stunad_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [stunad_pkg::CFG_DATA_W-1:0] cfg_data;

	// Parser mirror and transaction ID copy
	logic [16:0] attr_pos;
	logic [15:0] attr_code;
	logic [15:0] attr_len;
	logic [7:0]  attr_family;
	logic [15:0] attr_room;
	logic [31:0] tid_head_q;
	logic [63:0] tid_tail_q;

	stunad_pkg::result_t pending_decodes[$];
	int unsigned err_count;
	int unsigned cycle_count;
	int unsigned burst_left;
	int unsigned phase_items;
	bit          steady;
	bit          holdoff_req;
	bit          holdoff_issued;

	directed_row_t directed_rows [NUM_DIRECTED] = '{
		// short buffer on a first byte
		{8'hFF, 16'h0000, 1'b1, 8'hFF, stunad_pkg::ROLE_HEADER, 1'b1, stunad_pkg::ST_SHORT_BUF},
		// length 8 against 4 bytes available
		{8'h00, 16'h0004, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h01, 16'hFFFF, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h00, 16'h0000, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h08, 16'hFFFF, 1'b1, 8'h08, stunad_pkg::ROLE_HEADER, 1'b1,
			stunad_pkg::ST_LEN_TOO_BIG},
		// XOR-MAPPED-ADDRESS, IPv4, address equal to the cookie
		{8'h00, 16'hFFFF, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h20, 16'h0000, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h00, 16'hFFFF, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h08, 16'h0000, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h00, 16'hFFFF, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h01, 16'h0000, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h12, 16'hFFFF, 1'b1, 8'h33, stunad_pkg::ROLE_PORT, 1'b0, stunad_pkg::ST_OK},
		{8'h34, 16'h0000, 1'b1, 8'h26, stunad_pkg::ROLE_PORT, 1'b0, stunad_pkg::ST_OK},
		{8'h21, 16'hFFFF, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h12, 16'h0000, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'hA4, 16'hFFFF, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h42, 16'h0000, 1'b1, 8'h00, stunad_pkg::ROLE_ADDRESS, 1'b1, stunad_pkg::ST_OK},
		// ERROR-CODE with the class byte all ones
		{8'h00, 16'h0008, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h09, 16'hFFFF, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h00, 16'h0000, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h04, 16'hFFFF, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h00, 16'h0000, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'h00, 16'hFFFF, 1'b0, 8'h00, stunad_pkg::ROLE_HEADER, 1'b0, stunad_pkg::ST_OK},
		{8'hFF, 16'h0000, 1'b1, 8'h07, stunad_pkg::ROLE_ERRCODE, 1'b0, stunad_pkg::ST_OK},
		{8'h63, 16'hFFFF, 1'b1, 8'h63, stunad_pkg::ROLE_ERRCODE, 1'b1, stunad_pkg::ST_OK}
	};

	stun_attribute_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Decode one attribute byte and advance the parser mirror
	function automatic stunad_pkg::result_t decode_byte(input logic [7:0] d,
			input logic [15:0] avail);
		stunad_pkg::result_t r;
		logic [16:0]  body;
		logic [16:0]  pad;
		logic [16:0]  total;
		logic [4:0]   addr_size;
		logic [127:0] xor_key;
		logic         is_xor;
		logic         is_addr;
		int           idx;
		r.out_byte = d;
		r.byte_role = stunad_pkg::ROLE_HEADER;
		r.consumed_total = '0;
		r.last = 1'b0;
		r.status = stunad_pkg::ST_OK;
		xor_key = {stunad_pkg::MAGIC_COOKIE, tid_head_q, tid_tail_q};
		is_xor = (attr_code == stunad_pkg::T_XOR_MAPPED_ADDRESS) ||
			(attr_code == stunad_pkg::T_XOR_PEER_ADDRESS) ||
			(attr_code == stunad_pkg::T_XOR_RELAYED_ADDR);
		is_addr = is_xor || (attr_code == stunad_pkg::T_MAPPED_ADDRESS) ||
			(attr_code == stunad_pkg::T_ALT_ADDRESS);
		case (attr_pos)
			17'd0: begin
				attr_room = avail;
				attr_code = {d, 8'h00};
				attr_len = '0;
				attr_family = '0;
				if (avail < 16'(stunad_pkg::HDR_SIZE)) begin
					r.status = stunad_pkg::ST_SHORT_BUF;
					r.last = 1'b1;
				end
			end
			17'd1: attr_code[7:0] = d;
			17'd2: attr_len = {d, 8'h00};
			17'd3: begin
				attr_len[7:0] = d;
				if (attr_len > attr_room) begin
					r.status = stunad_pkg::ST_LEN_TOO_BIG;
					r.last = 1'b1;
				end
			end
			default: begin
				body = attr_pos - stunad_pkg::HDR_SIZE;
				addr_size = (attr_family == stunad_pkg::FAMILY_IPV6) ?
					stunad_pkg::ADDR_V6_SIZE : stunad_pkg::ADDR_V4_SIZE;
				if (body >= 17'(attr_len)) begin
					r.byte_role = stunad_pkg::ROLE_PADDING;
				end else if (is_addr) begin
					if (attr_pos == 17'd4) begin
						r.byte_role = stunad_pkg::ROLE_RESERVED;
					end else if (attr_pos == 17'd5) begin
						attr_family = d;
						r.byte_role = stunad_pkg::ROLE_FAMILY;
					end else if (attr_pos == 17'd6 || attr_pos == 17'd7) begin
						r.byte_role = stunad_pkg::ROLE_PORT;
						if (is_xor)
							r.out_byte = d ^ ((attr_pos == 17'd6) ?
								stunad_pkg::MAGIC_COOKIE[31:24] :
								stunad_pkg::MAGIC_COOKIE[23:16]);
					end else if (attr_pos - 17'd8 < 17'(addr_size)) begin
						r.byte_role = stunad_pkg::ROLE_ADDRESS;
						idx = int'(attr_pos) - 8;
						if (is_xor)
							r.out_byte = d ^ xor_key[127 - 8 * idx -: 8];
					end else begin
						r.byte_role = stunad_pkg::ROLE_VALUE;
					end
				end else if (attr_code == stunad_pkg::T_ERROR_CODE) begin
					if (attr_pos == 17'd4 || attr_pos == 17'd5) begin
						r.byte_role = stunad_pkg::ROLE_RESERVED;
					end else if (attr_pos == 17'd6) begin
						r.byte_role = stunad_pkg::ROLE_ERRCODE;
						r.out_byte = d & stunad_pkg::CLASS_MASK;
					end else if (attr_pos == 17'd7) begin
						r.byte_role = stunad_pkg::ROLE_ERRCODE;
					end else begin
						r.byte_role = stunad_pkg::ROLE_VALUE;
					end
				end else begin
					r.byte_role = stunad_pkg::ROLE_VALUE;
				end
			end
		endcase
		// Total size is known once the length is complete
		if (attr_pos >= 17'd3 && r.status == stunad_pkg::ST_OK) begin
			pad = (attr_len[1:0] != 2'b00) ? 17'd4 - 17'(attr_len[1:0]) : 17'd0;
			total = stunad_pkg::HDR_SIZE + 17'(attr_len) + pad;
			r.consumed_total = total;
			if (attr_pos + 17'd1 >= total)
				r.last = 1'b1;
		end
		attr_pos = r.last ? 17'd0 : attr_pos + 17'd1;
		r.attr_type = attr_code;
		r.attr_length = attr_len;
		r.xor_type = (attr_code == stunad_pkg::T_XOR_MAPPED_ADDRESS) ||
			(attr_code == stunad_pkg::T_XOR_PEER_ADDRESS) ||
			(attr_code == stunad_pkg::T_XOR_RELAYED_ADDR);
		r.ipv6_family = (attr_family == stunad_pkg::FAMILY_IPV6);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [16:0] got,
			input logic [16:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// Offer one item in bursts, record its decode once taken
	task automatic send_item(input logic [7:0] d, input logic [15:0] avail);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 48);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {avail, d};
		do @(posedge clk); while (!s_tready);
		pending_decodes.push_back(decode_byte(d, avail));
		burst_left--;
		phase_items++;
	endtask

	task automatic write_tid(input logic [31:0] head, input logic [63:0] tail);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= stunad_pkg::REG_TID_HEAD;
		cfg_data <= {32'h0, head};
		@(negedge clk);
		cfg_index <= stunad_pkg::REG_TID_TAIL;
		cfg_data <= tail;
		@(negedge clk);
		cfg_we <= 1'b0;
		tid_head_q = head;
		tid_tail_q = tail;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_decodes.size() != 0) @(posedge clk);
	endtask

	// Build and send one attribute: mostly well formed, some broken headers
	task automatic send_attribute();
		logic [15:0] code;
		logic [15:0] len;
		logic [15:0] avail;
		logic [15:0] low;
		logic [7:0]  fam;
		logic [7:0]  b;
		int unsigned kind;
		int unsigned pick;
		int unsigned total;
		kind = $urandom_range(0, 99);
		// short buffer
		if (kind < 8) begin
			send_item(8'($urandom), 16'($urandom_range(0, 3)));
			return;
		end
		// length beyond the buffer
		if (kind < 16) begin
			code = 16'($urandom);
			len = 16'($urandom_range(5, 65535));
			avail = 16'($urandom_range(4, len - 1));
			send_item(code[15:8], avail);
			send_item(code[7:0], 16'($urandom));
			send_item(len[15:8], 16'($urandom));
			send_item(len[7:0], 16'($urandom));
			return;
		end
		pick = $urandom_range(0, 19);
		case ($urandom_range(0, 3))
			0: fam = 8'h01;
			1, 2: fam = stunad_pkg::FAMILY_IPV6;
			default: fam = 8'($urandom);
		endcase
		if (pick < 12) begin
			case (pick % 5)
				0: code = stunad_pkg::T_MAPPED_ADDRESS;
				1: code = stunad_pkg::T_ALT_ADDRESS;
				2: code = stunad_pkg::T_XOR_MAPPED_ADDRESS;
				3: code = stunad_pkg::T_XOR_PEER_ADDRESS;
				default: code = stunad_pkg::T_XOR_RELAYED_ADDR;
			endcase
			if ($urandom_range(0, 3) != 0)
				len = (fam == stunad_pkg::FAMILY_IPV6) ? 16'd20 : 16'd8;
			else
				len = 16'($urandom_range(0, 28));
		end else if (pick < 15) begin
			code = stunad_pkg::T_ERROR_CODE;
			len = 16'($urandom_range(0, 24));
		end else begin
			code = 16'($urandom);
			len = 16'($urandom_range(0, 24));
		end
		if ($urandom_range(0, 99) == 0)
			len = 16'($urandom_range(64, 300));
		low = (len < 16'd4) ? 16'd4 : len;
		avail = ($urandom_range(0, 4) == 0) ? low : 16'($urandom_range(low, 65535));
		total = 4 + len + ((len % 4 != 0) ? 4 - len % 4 : 0);
		for (int unsigned i = 0; i < total; i++) begin
			case (i)
				0: b = code[15:8];
				1: b = code[7:0];
				2: b = len[15:8];
				3: b = len[7:0];
				5: b = fam;
				default: b = 8'($urandom);
			endcase
			send_item(b, (i == 0) ? avail : 16'($urandom));
		end
	endtask

	// Receiver readiness: changing patterns plus one long hold-off
	initial begin : receiver
		int unsigned mode;
		int unsigned left;
		int unsigned tick;
		mode = 0;
		left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
				holdoff_req = 1'b0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(32, 256);
			end
			left--;
			tick++;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (tick % 3 == 0);
				default: m_tready <= (tick % 8 == 0);
			endcase
		end
	end

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin : result_check
		stunad_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_decodes.size() == 0) begin
				report_mismatch($sformatf("unexpected item tdata %h tuser %h", m_tdata, m_tuser));
			end else begin
				want = pending_decodes.pop_front();
				check_field("out_byte", 17'(m_tdata[7:0]), 17'(want.out_byte));
				check_field("byte_role", 17'(m_tuser[2:0]), 17'(want.byte_role));
				check_field("attr_type", 17'(m_tdata[23:8]), 17'(want.attr_type));
				check_field("attr_length", 17'(m_tdata[39:24]), 17'(want.attr_length));
				check_field("consumed_total", m_tdata[56:40], want.consumed_total);
				check_field("xor_type", 17'(m_tuser[3]), 17'(want.xor_type));
				check_field("ipv6_family", 17'(m_tuser[4]), 17'(want.ipv6_family));
				check_field("last", 17'(m_tlast), 17'(want.last));
				check_field("status", 17'(m_tuser[6:5]), 17'(want.status));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		stunad_pkg::result_t patched;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = stunad_pkg::REG_TID_HEAD;
		cfg_data = '0;
		attr_pos = '0;
		attr_code = '0;
		attr_len = '0;
		attr_family = '0;
		attr_room = '0;
		tid_head_q = '0;
		tid_tail_q = '0;
		err_count = 0;
		cycle_count = 0;
		burst_left = 0;
		phase_items = 0;
		steady = 1'b0;
		holdoff_req = 1'b0;
		holdoff_issued = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table on reset transaction ID
		for (int unsigned i = 0; i < NUM_DIRECTED; i++) begin
			send_item(directed_rows[i].data, directed_rows[i].avail);
			if (directed_rows[i].typed) begin
				patched = pending_decodes.pop_back();
				patched.out_byte = directed_rows[i].out_byte;
				patched.byte_role = directed_rows[i].role;
				patched.last = directed_rows[i].last;
				patched.status = directed_rows[i].status;
				pending_decodes.push_back(patched);
			end
		end
		wait_drained();

		// Random attributes under several transaction IDs
		for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: write_tid(32'h0000_0000, 64'h0000_0000_0000_0000);
				1: write_tid(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
				2: write_tid($urandom, {$urandom, $urandom});
				3: write_tid(32'hFFFF_FFFF, 64'h0000_0000_0000_0000);
				default: write_tid(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
			endcase
			steady = (phase == 3);
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				if (phase == 1 && phase_items >= 60 && !holdoff_issued) begin
					holdoff_req = 1'b1;
					holdoff_issued = 1'b1;
				end
				send_attribute();
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
design/stunad_pkg.sv
design/stunad_decode.sv
design/stun_attribute_decoder.sv
design/stunad_checker.sv
tb/sv/stun_attribute_decoder_test.sv
